FILE: hdl/cbfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_pkg
// Shared constants, codes and types for the crop, bias and flat correction core.
// ----------------------------------------------------------------------------
package cbfc_pkg;

  localparam int unsigned InWidth    = 520;
  localparam int unsigned InHeight   = 70;
  localparam int unsigned OutWidth   = 64;
  localparam int unsigned OutHeight  = 64;
  localparam int unsigned ColumnStep = 8;

  localparam int unsigned OpW     = 2;
  localparam int unsigned RawW    = 16;
  localparam int unsigned StoreAw = 12;
  localparam int unsigned TValW   = 20;
  localparam int unsigned BiasW   = 20;
  localparam int unsigned FlatW   = 16;
  localparam int unsigned OutW    = 24;
  localparam int unsigned OffW    = 3;

  localparam int unsigned QueueDepth = 4;

  localparam logic [OffW-1:0]  RowOffsetReset = 3'd4;
  localparam logic [FlatW-1:0] FlatUnity      = 16'd4096;
  localparam logic [FlatW-1:0] FlatMax        = 16'hFFFF;

  localparam int unsigned RoundShift = 12;
  localparam int          RoundHalf  = 2048;
  localparam int          OutMax     = 8388607;
  localparam int          OutMin     = -8388608;

  typedef enum logic [OpW-1:0] {
    OpPixel = 2'd0,
    OpBias  = 2'd1,
    OpFlat  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KindPixel = 2'd0,
    KindBias  = 2'd1,
    KindFlat  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [StoreAw-1:0] addr;
    logic [TValW-1:0]   data;
    logic               last;
  } task_t;

  typedef struct packed {
    logic  valid;
    task_t item;
  } queue_req_t;

endpackage
`default_nettype wire

FILE: hdl/cbfc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_in_if
// Input channel: raw pixels and store load beats with valid/ready.
// ----------------------------------------------------------------------------
interface cbfc_in_if;
  import cbfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [RawW-1:0]    raw_pixel;
  logic               frame_start;
  logic [StoreAw-1:0] table_index;
  logic [TValW-1:0]   table_value;

  modport source (
    output valid, op, raw_pixel, frame_start, table_index, table_value,
    input  ready
  );

  modport sink (
    input  valid, op, raw_pixel, frame_start, table_index, table_value,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/cbfc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_out_if
// Output channel: corrected pixels with valid/ready.
// ----------------------------------------------------------------------------
interface cbfc_out_if;
  import cbfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StoreAw-1:0]     pixel_index;
  logic signed [OutW-1:0] corrected;
  logic                   saturated;
  logic                   frame_last;

  modport source (
    output valid, pixel_index, corrected, saturated, frame_last,
    input  ready
  );

  modport sink (
    input  valid, pixel_index, corrected, saturated, frame_last,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/crop_bias_flat_correction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crop_bias_flat_correction_core
// Crops and decimates a raw sensor frame to a 64x64 image with reversed
// column order and applies per-pixel bias subtraction and flat gain.
//
// in_i carries raw pixels (op pixel) and bias/flat store loads, one beat
// per cycle while in_i.ready is high. out_o carries one beat per kept pixel:
// index, corrected value in signed q20.4, a clip flag and an end-of-frame
// flag. cfg_we_i/cfg_data_i set the first kept sensor row (reset value 4).
// Throughput is one input beat per cycle while in_i.ready is high. A kept
// pixel passes through the task queue; the queue head is read from both
// stores into the s1 registers, the product into s2 and the rounded and
// clipped value into the output register. After reset the back end clears
// both stores, one entry per cycle, so in_i.ready stays low until all 4096
// entries are cleared. When out_o stalls the back pipeline holds, the
// four-entry task queue fills and then in_i.ready drops.
// ----------------------------------------------------------------------------
module crop_bias_flat_correction_core #(
  parameter int unsigned IN_WIDTH    = cbfc_pkg::InWidth,
  parameter int unsigned IN_HEIGHT   = cbfc_pkg::InHeight,
  parameter int unsigned OUT_WIDTH   = cbfc_pkg::OutWidth,
  parameter int unsigned OUT_HEIGHT  = cbfc_pkg::OutHeight,
  parameter int unsigned COLUMN_STEP = cbfc_pkg::ColumnStep
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cbfc_in_if.sink                        in_i,
  cbfc_out_if.source                     out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [cbfc_pkg::OffW-1:0] cfg_data_i
);
  import cbfc_pkg::*;

  logic [OffW-1:0] row_offset_q;
  queue_req_t      push;
  logic            queue_full;
  logic            pop;
  logic            task_valid;
  task_t           task_head;
  logic            back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_offset_q <= RowOffsetReset;
    end else if (cfg_we_i) begin
      row_offset_q <= cfg_data_i;
    end
  end

  cbfc_front #(
    .IN_WIDTH    (IN_WIDTH),
    .IN_HEIGHT   (IN_HEIGHT),
    .OUT_WIDTH   (OUT_WIDTH),
    .OUT_HEIGHT  (OUT_HEIGHT),
    .COLUMN_STEP (COLUMN_STEP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .row_offset_i (row_offset_q),
    .enable_i     (back_ready),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  cbfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (task_valid),
    .item_o  (task_head)
  );

  cbfc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (task_valid),
    .item_i  (task_head),
    .pop_o   (pop),
    .ready_o (back_ready),
    .out_o   (out_o)
  );
endmodule
`default_nettype wire

FILE: hdl/cbfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_front
// Accepts input beats, tracks the sensor position and turns kept pixels and
// store loads into tasks for the back end.
// ----------------------------------------------------------------------------
module cbfc_front #(
  parameter int unsigned IN_WIDTH    = cbfc_pkg::InWidth,
  parameter int unsigned IN_HEIGHT   = cbfc_pkg::InHeight,
  parameter int unsigned OUT_WIDTH   = cbfc_pkg::OutWidth,
  parameter int unsigned OUT_HEIGHT  = cbfc_pkg::OutHeight,
  parameter int unsigned COLUMN_STEP = cbfc_pkg::ColumnStep
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cbfc_in_if.sink                        in_i,
  input  wire logic [cbfc_pkg::OffW-1:0] row_offset_i,
  input  wire logic                      enable_i,
  input  wire logic                      queue_full_i,
  output cbfc_pkg::queue_req_t           push_o
);
  import cbfc_pkg::*;

  localparam int unsigned ColW = $clog2(IN_WIDTH);
  localparam int unsigned RowW = $clog2(IN_HEIGHT);
  localparam int unsigned PhW  = (COLUMN_STEP > 1) ? $clog2(COLUMN_STEP) : 1;

  logic [ColW-1:0] col_q, col_d, cur_col;
  logic [RowW-1:0] row_q, row_d, cur_row;
  logic [PhW-1:0]  phase_q, phase_d, cur_phase;
  logic [ColW-1:0] quo_q, quo_d, cur_quo;
  logic [RowW-1:0] rdiff;
  logic            accept, keep;
  logic            pix_beat;

  assign in_i.ready = enable_i && !queue_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign pix_beat   = accept && (in_i.op == OpPixel);

  // position of this sample, frame start forces the origin
  always_comb begin
    cur_col   = in_i.frame_start ? '0 : col_q;
    cur_row   = in_i.frame_start ? '0 : row_q;
    cur_phase = in_i.frame_start ? '0 : phase_q;
    cur_quo   = in_i.frame_start ? '0 : quo_q;
  end

  always_comb begin
    if (cur_col == ColW'(IN_WIDTH - 1)) begin
      col_d   = '0;
      phase_d = '0;
      quo_d   = '0;
      row_d   = (cur_row == RowW'(IN_HEIGHT - 1)) ? '0 : cur_row + RowW'(1);
    end else begin
      col_d = cur_col + ColW'(1);
      row_d = cur_row;
      if (cur_phase == PhW'(COLUMN_STEP - 1)) begin
        phase_d = '0;
        quo_d   = cur_quo + ColW'(1);
      end else begin
        phase_d = cur_phase + PhW'(1);
        quo_d   = cur_quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      quo_q   <= '0;
    end else if (pix_beat) begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      quo_q   <= quo_d;
    end
  end

  assign rdiff = cur_row - RowW'(row_offset_i);
  assign keep  = (cur_row >= RowW'(row_offset_i))
              && ({1'b0, rdiff} < (RowW + 1)'(OUT_HEIGHT))
              && (cur_phase == '0)
              && (cur_quo != '0)
              && ({1'b0, cur_quo} <= (ColW + 1)'(OUT_WIDTH));

  always_comb begin
    push_o.valid     = 1'b0;
    push_o.item.kind = KindPixel;
    push_o.item.addr = in_i.table_index;
    push_o.item.data = in_i.table_value;
    push_o.item.last = 1'b0;
    unique case (op_e'(in_i.op))
      OpPixel: begin
        push_o.valid     = accept && keep;
        push_o.item.addr = StoreAw'(rdiff) * StoreAw'(OUT_WIDTH)
                         + StoreAw'(OUT_WIDTH) - StoreAw'(cur_quo);
        push_o.item.data = TValW'(in_i.raw_pixel);
        push_o.item.last = ({1'b0, rdiff} == (RowW + 1)'(OUT_HEIGHT - 1))
                        && ({1'b0, cur_quo} == (ColW + 1)'(OUT_WIDTH));
      end
      OpBias: begin
        push_o.valid     = accept;
        push_o.item.kind = KindBias;
      end
      OpFlat: begin
        push_o.valid     = accept;
        push_o.item.kind = KindFlat;
        // clip gain to the store width
        push_o.item.data = (in_i.table_value > TValW'(FlatMax)) ?
                           TValW'(FlatMax) : in_i.table_value;
      end
      default: push_o.valid = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/cbfc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_queue
// Short task queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cbfc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cbfc_pkg::queue_req_t push_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output cbfc_pkg::task_t           item_o
);
  import cbfc_pkg::*;

  localparam int unsigned QAw = $clog2(QueueDepth);

  task_t          slot_q [QueueDepth];
  logic [QAw:0]   wr_q, wr_d, rd_q, rd_d;

  assign valid_o = (wr_q != rd_q);
  assign full_o  = (wr_q[QAw] != rd_q[QAw]) && (wr_q[QAw-1:0] == rd_q[QAw-1:0]);
  assign item_o  = slot_q[rd_q[QAw-1:0]];

  assign wr_d = wr_q + (QAw + 1)'(1);
  assign rd_d = rd_q + (QAw + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_d;
      if (pop_i)        rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_q[QAw-1:0]] <= push_i.item;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cbfc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbfc_back
// Holds the bias and flat stores, runs the correction pipeline and drives
// the output channel. Clears the stores after reset.
// ----------------------------------------------------------------------------
module cbfc_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire cbfc_pkg::task_t item_i,
  output logic              pop_o,
  output logic              ready_o,
  cbfc_out_if.source        out_o
);
  import cbfc_pkg::*;

  localparam int unsigned StoreDepth = 1 << StoreAw;
  localparam int unsigned DiffW      = RawW + 5;
  localparam int unsigned PrdW       = DiffW + FlatW + 1;
  localparam int unsigned RndW       = PrdW - RoundShift;
  localparam logic signed [RndW-1:0] RndMax = RndW'(OutMax);
  localparam logic signed [RndW-1:0] RndMin = RndW'(OutMin);

  logic [BiasW-1:0] bias_mem [StoreDepth];
  logic [FlatW-1:0] flat_mem [StoreDepth];

  logic               clr_busy_q;
  logic [StoreAw-1:0] clr_q;

  logic               advance;
  logic [BiasW-1:0]   bias_rd_q;
  logic [FlatW-1:0]   flat_rd_q;

  logic               s1_valid_q;
  logic [RawW-1:0]    s1_raw_q;
  logic [StoreAw-1:0] s1_idx_q;
  logic               s1_last_q;

  logic                   s2_valid_q;
  logic signed [PrdW-1:0] s2_prod_q;
  logic [StoreAw-1:0]     s2_idx_q;
  logic                   s2_last_q;

  logic                   out_valid_q;
  logic [StoreAw-1:0]     out_idx_q;
  logic signed [OutW-1:0] out_val_q, out_val_d;
  logic                   out_sat_q, out_sat_d;
  logic                   out_last_q;

  logic signed [DiffW-1:0] diff;
  logic signed [PrdW-1:0]  prod, rsum;
  logic signed [RndW-1:0]  rnd;

  assign ready_o = !clr_busy_q;
  assign advance = !out_valid_q || out_o.ready;
  assign pop_o   = valid_i && advance && !clr_busy_q;

  // store clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + StoreAw'(1);
      if (clr_q == '1) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      bias_mem[clr_q] <= '0;
    end else if (pop_o && item_i.kind == KindBias) begin
      bias_mem[item_i.addr] <= item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      flat_mem[clr_q] <= FlatUnity;
    end else if (pop_o && item_i.kind == KindFlat) begin
      flat_mem[item_i.addr] <= item_i.data[FlatW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bias_rd_q <= bias_mem[item_i.addr];
      flat_rd_q <= flat_mem[item_i.addr];
    end
  end

  // raw in q16.4 minus bias, times q4.12 gain
  assign diff = $signed({1'b0, s1_raw_q, 4'b0000}) - $signed({1'b0, bias_rd_q});
  assign prod = PrdW'(diff * $signed({1'b0, flat_rd_q}));

  // round half up, then clip to q20.4
  assign rsum = s2_prod_q + PrdW'(RoundHalf);
  assign rnd  = rsum[PrdW-1:RoundShift];

  always_comb begin
    out_sat_d = 1'b0;
    out_val_d = OutW'(rnd);
    if (rnd > RndMax) begin
      out_val_d = OutW'(RndMax);
      out_sat_d = 1'b1;
    end else if (rnd < RndMin) begin
      out_val_d = OutW'(RndMin);
      out_sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o && item_i.kind == KindPixel;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_raw_q   <= item_i.data[RawW-1:0];
      s1_idx_q   <= item_i.addr;
      s1_last_q  <= item_i.last;
      s2_prod_q  <= prod;
      s2_idx_q   <= s1_idx_q;
      s2_last_q  <= s1_last_q;
      out_idx_q  <= s2_idx_q;
      out_val_q  <= out_val_d;
      out_sat_q  <= out_sat_d;
      out_last_q <= s2_last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_index = out_idx_q;
  assign out_o.corrected   = out_val_q;
  assign out_o.saturated   = out_sat_q;
  assign out_o.frame_last  = out_last_q;
endmodule
`default_nettype wire

FILE: tb/tb_crop_bias_flat_correction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_crop_bias_flat_correction_core
// Self-checking bench for the crop, bias and flat correction core. A queue
// fed driver sends raw pixels and store loads, a bit-true predictor tracks
// the sensor position, both stores and the row offset, and a monitor
// compares every output beat with the oldest predicted pixel. Short frame
// pieces run under row offsets 0 and 1 and sender/receiver idling mixes,
// with restarted and unmarked frames and extra load and unused-op noise.
// ----------------------------------------------------------------------------
module tb_crop_bias_flat_correction_core;
  import cbfc_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned StoreDepth = 1 << StoreAw;
  localparam int DrainCycles = 16;

  typedef struct {
    logic [OpW-1:0]     op;
    logic [RawW-1:0]    raw_pixel;
    logic               frame_start;
    logic [StoreAw-1:0] table_index;
    logic [TValW-1:0]   table_value;
  } in_beat_t;

  typedef struct {
    logic [StoreAw-1:0]     pixel_index;
    logic signed [OutW-1:0] corrected;
    logic                   saturated;
    logic                   frame_last;
  } out_pixel_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [OffW-1:0] cfg_data_i;

  cbfc_in_if  in_if();
  cbfc_out_if out_if();

  crop_bias_flat_correction_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  in_beat_t         beats_to_send[$];
  out_pixel_t       expected_pixels[$];
  in_beat_t         next_beat;
  out_pixel_t       oldest_pixel;
  logic [BiasW-1:0] bias_table[StoreDepth];
  logic [FlatW-1:0] flat_table[StoreDepth];
  int unsigned      row_offset_now;
  int unsigned      column_pos;
  int unsigned      row_pos;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               error_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic push_beat(input logic [OpW-1:0] op, input logic [RawW-1:0] raw,
                           input logic fs, input logic [StoreAw-1:0] idx,
                           input logic [TValW-1:0] val);
    in_beat_t b;
    b = '{op, raw, fs, idx, val};
    beats_to_send.push_back(b);
  endtask

  // a run of raw pixels, first one optionally marked, with loads and unused ops mixed in
  task automatic queue_frame(input logic mark, input int unsigned pixels,
                             input int unsigned noise_pct);
    logic [RawW-1:0]  raw;
    logic [TValW-1:0] val;
    logic [OpW-1:0]   op;
    for (int unsigned n = 0; n < pixels; n++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(9))
          0: op = OpUnused;
          1, 2, 3, 4: op = OpBias;
          default: op = OpFlat;
        endcase
        case ($urandom_range(4))
          0: val = '0;
          1: val = '1;
          2: val = TValW'(FlatUnity);
          3: val = TValW'($urandom_range(65535));
          default: val = TValW'($urandom);
        endcase
        push_beat(op, RawW'($urandom), 1'($urandom), StoreAw'($urandom), val);
      end
      case ($urandom_range(7))
        0: raw = '0;
        1: raw = '1;
        default: raw = RawW'($urandom);
      endcase
      push_beat(OpPixel, raw, (n == 0) ? mark : 1'b0, StoreAw'($urandom),
                TValW'($urandom));
    end
  endtask

  task automatic correct_beat(input in_beat_t b);
    int unsigned r, c, q, orow, ocol;
    longint      diff, prod, val;
    out_pixel_t  px;
    if (b.op == OpBias) begin
      bias_table[b.table_index] = b.table_value;
    end else if (b.op == OpFlat) begin
      flat_table[b.table_index] = (b.table_value > TValW'(FlatMax)) ?
                                  FlatMax : b.table_value[FlatW-1:0];
    end else if (b.op == OpPixel) begin
      if (b.frame_start) begin
        column_pos = 0;
        row_pos = 0;
      end
      r = row_pos;
      c = column_pos;
      column_pos++;
      if (column_pos >= InWidth) begin
        column_pos = 0;
        row_pos++;
        if (row_pos >= InHeight) row_pos = 0;
      end
      q = c / ColumnStep;
      if (r >= row_offset_now && r - row_offset_now < OutHeight &&
          c % ColumnStep == 0 && q >= 1 && q <= OutWidth) begin
        orow = r - row_offset_now;
        ocol = OutWidth - q;
        px.pixel_index = StoreAw'(orow * OutWidth + ocol);
        diff = longint'(b.raw_pixel) * 16 - longint'(bias_table[px.pixel_index]);
        prod = diff * longint'(flat_table[px.pixel_index]);
        val = (prod + RoundHalf) >>> RoundShift;
        px.saturated = 1'b0;
        if (val > OutMax) begin
          val = OutMax;
          px.saturated = 1'b1;
        end else if (val < OutMin) begin
          val = OutMin;
          px.saturated = 1'b1;
        end
        px.corrected = OutW'(val);
        px.frame_last = (orow == OutHeight - 1 && ocol == 0);
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_if.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_row_offset(input logic [OffW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    row_offset_now = v;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_if.valid <= 1'b1;
        in_if.op <= next_beat.op;
        in_if.raw_pixel <= next_beat.raw_pixel;
        in_if.frame_start <= next_beat.frame_start;
        in_if.table_index <= next_beat.table_index;
        in_if.table_value <= next_beat.table_value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // input beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      correct_beat('{in_if.op, in_if.raw_pixel, in_if.frame_start,
                     in_if.table_index, in_if.table_value});
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $error("unexpected beat: pixel_index %0d", out_if.pixel_index);
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        check_field("pixel_index", {20'd0, oldest_pixel.pixel_index},
                    {20'd0, out_if.pixel_index});
        check_field("corrected", oldest_pixel.corrected, out_if.corrected);
        check_field("saturated", {31'd0, oldest_pixel.saturated},
                    {31'd0, out_if.saturated});
        check_field("frame_last", {31'd0, oldest_pixel.frame_last},
                    {31'd0, out_if.frame_last});
      end
    end
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.op = OpPixel;
    in_if.raw_pixel = '0;
    in_if.frame_start = 1'b0;
    in_if.table_index = '0;
    in_if.table_value = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    row_offset_now = RowOffsetReset;
    column_pos = 0;
    row_pos = 0;
    for (int unsigned k = 0; k < StoreDepth; k++) begin
      bias_table[k] = '0;
      flat_table[k] = FlatUnity;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // store extremes, frame start on loads, unused op
    push_beat(OpBias, '1, 1'b1, 12'd0, '1);
    push_beat(OpFlat, '0, 1'b1, 12'd0, '1);
    push_beat(OpFlat, '1, 1'b0, '1, '0);
    push_beat(OpBias, '0, 1'b0, '1, '0);
    push_beat(OpFlat, '0, 1'b0, 12'd63, TValW'(FlatMax));
    push_beat(OpBias, '0, 1'b0, 12'd63, '0);
    push_beat(OpFlat, '0, 1'b0, 12'd4032, 20'h10000);
    push_beat(OpBias, '0, 1'b0, 12'd4032, 20'h10000);
    push_beat(OpBias, '0, 1'b0, 12'd1, 20'h12345);
    push_beat(OpFlat, '0, 1'b0, 12'd1, 20'h00800);
    push_beat(OpUnused, '1, 1'b1, '1, '1);
    push_beat(OpUnused, '0, 1'b0, '0, '0);
    wait_drained();

    set_row_offset(3'd0);
    queue_frame(1'b1, 400, 3);
    wait_drained();

    // counters run on into the next row without a frame start
    send_idle_pct = 55;
    queue_frame(1'b0, 300, 3);
    wait_drained();

    set_row_offset(3'd1);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    queue_frame(1'b0, 300, 3);
    wait_drained();

    // restarted frames with heavier noise
    set_row_offset(3'd0);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    repeat (3) queue_frame(1'b1, $urandom_range(200, 100), 10);
    wait_drained();

    if (error_count == 0) begin
      $display("PASS crop_bias_flat_correction_core");
    end else begin
      $display("FAIL crop_bias_flat_correction_core");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL crop_bias_flat_correction_core");
    $finish;
  end

endmodule
`default_nettype wire
